FILE: design/m128cp_pkg.sv
// shared types and constants for the 128-bit product chaotic generator
package m128cp_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned HALF_W   = 32;
    localparam int unsigned PROD_W   = 2 * WORD_W;
    localparam int unsigned ROUNDS_W = 8;

    localparam logic [WORD_W-1:0]   INC_LOW        = 64'h5555_5555_5555_5555;
    localparam logic [WORD_W-1:0]   INC_HIGH       = 64'haaaa_aaaa_aaaa_aaaa;
    localparam logic [ROUNDS_W-1:0] ROUNDS_DEFAULT = 8'd8;

    // input command codes
    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    // partial product selects: bit 0 picks the upper half of a, bit 1 of b
    typedef enum logic [1:0] {
        PP_A0B0 = 2'd0,
        PP_A1B0 = 2'd1,
        PP_A0B1 = 2'd2,
        PP_A1B1 = 2'd3
    } pp_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_LAST
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load_seed;
        logic    sum_en;
        logic    mul_en;
        pp_sel_t mul_sel;
        logic    acc_clr;
        logic    acc_en;
        pp_sel_t acc_sel;
        logic    commit;
        logic    out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

FILE: design/mul128_chaotic_prng.sv
// top level of the 128-bit product chaotic random word generator
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------
//  input    | in_valid / in_stall    | command, seed_value
//  output   | out_valid / out_stall  | random_word
//  config   | cfg_write_en           | cfg_write_data (warm-up rounds)
//
// a next command runs an accept step, an offset-sum step, four passes through
// the single 32x32 multiplier and one final accumulate that also updates the
// state words; that last step waits while the output beat is stalled
// a seed command runs warmup_rounds silent steps and gives no beat
// reset clears both state words and sets warmup_rounds to 8
// input is taken only while no step is in progress; the output register lets
// a new item be taken while a beat waits, and a finished step holds in its last
// cycle while out_stall keeps the previous beat in place
module mul128_chaotic_prng (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [63:0] seed_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] random_word,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data
);
    import m128cp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    m128cp_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .status         (status),
        .cmd            (cmd)
    );

    m128cp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .seed_value  (seed_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

    // a new beat never overwrites one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("output beat overwritten while stalled");

    // a next command always starts a step
    a_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && command == CMD_NEXT) |=> in_stall)
        else $error("next command did not start a step");

    // a beat appears only from a completed step
    a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load && cmd.commit))
        else $error("output beat without a completed step");

    // seeding and state update never collide
    a_seed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_seed |-> !cmd.commit && !cmd.acc_en)
        else $error("seed load during a step");

endmodule

FILE: design/m128cp_ctrl.sv
// controller: sequences seed loads, warm-up steps and partial product passes
module m128cp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   command,
    input  logic                   cfg_write_en,
    input  logic [7:0]             cfg_write_data,
    input  m128cp_pkg::dp_status_t status,
    output m128cp_pkg::ctrl_cmd_t  cmd
);
    import m128cp_pkg::*;

    state_t              state_reg, state_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [ROUNDS_W-1:0] warm_reg, warm_next;
    logic [ROUNDS_W-1:0] rounds_reg;
    logic                emit_reg, emit_next;
    logic                accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // warm-up round count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounds_reg <= ROUNDS_DEFAULT;
        end
        else if (cfg_write_en)
        begin
            rounds_reg <= cfg_write_data[ROUNDS_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
            warm_reg  <= '0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            warm_reg  <= warm_next;
            emit_reg  <= emit_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        warm_next  = warm_reg;
        emit_next  = emit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_NEXT)
                    begin
                        emit_next  = 1'b1;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        emit_next  = 1'b0;
                        warm_next  = rounds_reg;
                        state_next = (rounds_reg == '0) ? ST_IDLE : ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                cnt_next   = 2'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (emit_reg)
                begin
                    if (status.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    warm_next  = warm_reg - 8'd1;
                    state_next = (warm_reg == 8'd1) ? ST_IDLE : ST_SUM;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.mul_sel   = pp_sel_t'(cnt_reg);
        cmd.acc_sel   = pp_sel_t'(cnt_reg - 2'd1);
        cmd.load_seed = accept && (command == CMD_SEED);
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SUM:
            begin
                cmd.sum_en  = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.acc_en = (cnt_reg != 2'd0);
            end
            ST_LAST:
            begin
                // last partial product lands in the same cycle as the state update
                cmd.acc_sel  = PP_A1B1;
                cmd.acc_en   = !emit_reg || status.out_free;
                cmd.commit   = !emit_reg || status.out_free;
                cmd.out_load = emit_reg && status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: design/m128cp_dp.sv
// datapath: state words, 32x32 partial product multiplier, accumulator, output beat
module m128cp_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  m128cp_pkg::ctrl_cmd_t  cmd,
    output m128cp_pkg::dp_status_t status,
    input  logic [63:0]            seed_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [63:0]            random_word
);
    import m128cp_pkg::*;

    logic [WORD_W-1:0] low_reg, high_reg;
    logic [WORD_W-1:0] a_reg, b_reg;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] acc_reg, acc_next, addend;
    logic [HALF_W-1:0] a_half, b_half;
    logic [WORD_W-1:0] out_data_reg;
    logic              out_valid_reg;

    // state words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
        end
        else if (cmd.load_seed)
        begin
            low_reg  <= seed_value;
            high_reg <= seed_value;
        end
        else if (cmd.commit)
        begin
            low_reg  <= acc_next[WORD_W-1:0];
            high_reg <= acc_next[PROD_W-1:WORD_W];
        end
    end

    // offset sums that feed the multiply
    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            a_reg <= low_reg + INC_LOW;
            b_reg <= high_reg + INC_HIGH;
        end
    end

    // one 32x32 partial product per cycle while mul_en is set
    assign a_half    = cmd.mul_sel[0] ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_half    = cmd.mul_sel[1] ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];
    assign prod_next = a_half * b_half;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // place the registered partial product at its weight and accumulate
    always_comb
    begin
        unique case (cmd.acc_sel)
            PP_A0B0: addend = {{WORD_W{1'b0}}, prod_reg};
            PP_A1B0,
            PP_A0B1: addend = {{HALF_W{1'b0}}, prod_reg, {HALF_W{1'b0}}};
            PP_A1B1: addend = {prod_reg, {WORD_W{1'b0}}};
            default: addend = '0;
        endcase
    end

    assign acc_next = acc_reg + addend;

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= acc_next[WORD_W-1:0] ^ acc_next[PROD_W-1:WORD_W];
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign random_word     = out_data_reg;

endmodule

FILE: test/tb_mul128_chaotic_prng.sv
// self-checking testbench for the 128-bit product chaotic random word generator
`timescale 1ns / 1ps

module tb_mul128_chaotic_prng;
    import m128cp_pkg::*;

    localparam int unsigned CLK_HALF    = 4;
    localparam int unsigned RESET_LEN   = 6;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // longest silent warm-up the block can run, plus margin
    localparam int unsigned SETTLE_LEN  = 6 * 255 + 32;
    localparam logic [7:0]  CFG_INDEX   = 8'd0;

    // expected-word tracker with its own copy of the generator state
    class prng_scoreboard;
        logic [WORD_W-1:0]   low_state;
        logic [WORD_W-1:0]   high_state;
        logic [ROUNDS_W-1:0] warmup_cfg;
        logic [WORD_W-1:0]   pending_words[$];
        int                  errors;

        function new();
            low_state  = '0;
            high_state = '0;
            warmup_cfg = ROUNDS_DEFAULT;
            errors     = 0;
        endfunction

        function void set_rounds(logic [7:0] index, logic [ROUNDS_W-1:0] value);
            if (index == CFG_INDEX)
                warmup_cfg = value;
        endfunction

        // one generator step: offset both words, full product, split halves
        function logic [WORD_W-1:0] advance_state();
            logic [PROD_W-1:0] prod;
            logic [WORD_W-1:0] sum_lo;
            logic [WORD_W-1:0] sum_hi;
            sum_lo = low_state + INC_LOW;
            sum_hi = high_state + INC_HIGH;
            prod = {{WORD_W{1'b0}}, sum_lo} * {{WORD_W{1'b0}}, sum_hi};
            low_state  = prod[WORD_W-1:0];
            high_state = prod[PROD_W-1:WORD_W];
            return low_state ^ high_state;
        endfunction

        // accepted input beat
        function void note_command(logic cmd, logic [WORD_W-1:0] seed);
            if (cmd == CMD_SEED)
            begin
                low_state  = seed;
                high_state = seed;
                for (int i = 0; i < warmup_cfg; i++)
                    void'(advance_state());
            end
            else
            begin
                pending_words.push_back(advance_state());
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        task report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
            errors++;
        endtask

        // accepted output beat
        task check_word(logic [WORD_W-1:0] got);
            logic [WORD_W-1:0] want;
            if (pending_words.size() == 0)
            begin
                report_mismatch("unexpected random_word", got, '0);
            end
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                    report_mismatch("random_word", got, want);
            end
        endtask
    endclass

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic              command        = CMD_NEXT;
    logic [WORD_W-1:0] seed_value     = '0;
    logic              out_valid;
    logic              out_stall      = 1'b0;
    logic [WORD_W-1:0] random_word;
    logic              cfg_write_en   = 1'b0;
    logic [7:0]        cfg_write_data = '0;

    bit                idle_on        = 1'b1;
    int unsigned       cycle_count    = 0;
    prng_scoreboard    sb             = new();

    mul128_chaotic_prng uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .seed_value     (seed_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .random_word    (random_word),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // output beats go to the checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(random_word);
    end

    // receiver back-pressure in random bursts
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // seed picker biased toward edge values
    function automatic logic [WORD_W-1:0] pick_seed();
        logic [WORD_W-1:0] one_hot;
        one_hot = {{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_W - 1);
        unique case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return one_hot;
            3: return ~one_hot;
            4: return -INC_LOW;
            5: return -INC_HIGH;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one input beat, with an optional gap in front
    task automatic send_item(logic cmd, logic [WORD_W-1:0] seed);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        seed_value <= seed;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_command(cmd, seed);
    endtask

    // hold the sender until every expected word has come back
    task automatic hold_until_empty();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() > 0);
    endtask

    // wait out any silent warm-up before touching the register
    task automatic quiesce();
        hold_until_empty();
        repeat (SETTLE_LEN) @(posedge clk);
    endtask

    task automatic write_rounds(logic [ROUNDS_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.set_rounds(CFG_INDEX, value);
    endtask

    // mostly seed-then-next runs, some loose beats
    task automatic run_random(int count);
        int sent;
        int run_len;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(logic'($urandom_range(0, 1)), {$urandom, $urandom});
                sent++;
            end
            else
            begin
                send_item(CMD_SEED, pick_seed());
                run_len = $urandom_range(1, 12);
                for (int i = 0; i < run_len; i++)
                    send_item(CMD_NEXT, {$urandom, $urandom});
                sent += run_len + 1;
            end
        end
    endtask

    initial
    begin
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default warm-up, next before any seed runs on the reset state
        send_item(CMD_NEXT, '1);
        send_item(CMD_NEXT, '0);
        send_item(CMD_SEED, '0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_NEXT, '1);
        send_item(CMD_SEED, '1);
        send_item(CMD_NEXT, '0);
        send_item(CMD_SEED, -INC_LOW);
        send_item(CMD_NEXT, '0);

        // zero warm-up, starting from a zero seed and other edge seeds
        quiesce();
        write_rounds(8'd0);
        send_item(CMD_SEED, '0);
        repeat (4) send_item(CMD_NEXT, '0);
        send_item(CMD_SEED, INC_LOW);
        send_item(CMD_NEXT, '1);
        send_item(CMD_SEED, {1'b1, {(WORD_W-1){1'b0}}});
        send_item(CMD_NEXT, '0);

        // longest warm-up, kept short in item count
        quiesce();
        write_rounds(8'd255);
        send_item(CMD_SEED, {$urandom, $urandom});
        send_item(CMD_NEXT, '0);
        send_item(CMD_NEXT, '1);
        run_random(30);

        // single warm-up step, with one full drain in the middle
        quiesce();
        write_rounds(8'd1);
        run_random(150);
        hold_until_empty();
        run_random(150);

        quiesce();
        write_rounds(8'd0);
        run_random(300);

        quiesce();
        write_rounds(ROUNDS_W'($urandom_range(2, 24)));
        run_random(300);

        quiesce();
        write_rounds(ROUNDS_W'($urandom_range(2, 24)));
        run_random(300);

        // back to the default, full rate on both sides
        quiesce();
        write_rounds(ROUNDS_DEFAULT);
        idle_on = 1'b0;
        run_random(640);

        hold_until_empty();
        repeat (SETTLE_LEN) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: mul128_chaotic_prng.f
design/m128cp_pkg.sv
design/m128cp_ctrl.sv
design/m128cp_dp.sv
design/mul128_chaotic_prng.sv
test/tb_mul128_chaotic_prng.sv
